### sv/assert_macros.svh
// Assertion helpers used by the top-level cipher.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising edge, held off during reset.
`define ASSERT_IMPL(label, clk, rst_n, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
		else $error(msg);

// Implication checked in the cycle after the condition.
`define ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
		else $error(msg);

`endif

### sv/sk_pkg.sv
package sk_pkg;

	localparam int NumRounds = 56;
	localparam int CfgIdxW   = 2;
	localparam int RegW      = 64;

	typedef enum logic [CfgIdxW-1:0] {
		REG_TK2_LOW  = 2'd0,
		REG_TK2_HIGH = 2'd1,
		REG_TK3_LOW  = 2'd2,
		REG_TK3_HIGH = 2'd3
	} reg_idx_t;

	typedef logic [7:0] byte_arr_t [16];

	function automatic logic [7:0] sbox_calc(input logic [7:0] xi);
		logic [7:0] x;
		logic n4;
		logic n0;
		x = xi;
		for (int it = 0; it < 4; it++) begin
			n4 = ~(x[7] | x[6]);
			n0 = ~(x[3] | x[2]);
			x = x ^ {3'b000, n4, 3'b000, n0};
			if (it < 3) begin
				x = {x[2], x[1], x[7], x[6], x[4], x[0], x[3], x[5]};
			end else begin
				x = {x[7:3], x[1], x[2], x[0]};
			end
		end
		return x;
	endfunction

	function automatic logic [7:0] fwd_box(input logic [7:0] v);
		return sbox_calc(v);
	endfunction

	function automatic logic [7:0] inv_box(input logic [7:0] v);
		logic [7:0] r;
		r = 8'h00;
		for (int k = 0; k < 256; k++) begin
			if (sbox_calc(8'(k)) == v) begin
				r = 8'(k);
			end
		end
		return r;
	endfunction

	function automatic logic [127:0] perm_tk(input logic [127:0] c);
		localparam int P [16] = '{9, 15, 8, 13, 10, 14, 12, 11, 0, 1, 2, 3, 4, 5, 6, 7};
		logic [127:0] t;
		for (int i = 0; i < 16; i++) begin
			t[8*i +: 8] = c[8*P[i] +: 8];
		end
		return t;
	endfunction

	function automatic logic [5:0] rc_next(input logic [5:0] rc);
		return {rc[4:0], 1'b0} ^ {5'b0, rc[5]} ^ {5'b0, rc[4]} ^ 6'h01;
	endfunction

endpackage

### sv/sk_round.sv
// One cipher round, forward or inverse; pure combinational.
module sk_round (
	input  logic         dec,
	input  logic [127:0] s_in,
	input  logic [63:0]  rk,
	input  logic [63:0]  tk1,
	output logic [127:0] s_out
);

	localparam int RS [16] = '{0, 1, 2, 3, 7, 4, 5, 6, 10, 11, 8, 9, 13, 14, 15, 12};

	logic [127:0] a;
	logic [127:0] b;
	logic [127:0] t;
	logic [127:0] ark;
	logic [7:0] a0, a1, a2, a3, b0, b1, b2, b3;

	always_comb begin
		ark = {56'h0, 8'h02, rk ^ tk1};
		a = '0;
		b = '0;
		t = '0;
		s_out = '0;
		a0 = '0;
		a1 = '0;
		a2 = '0;
		a3 = '0;
		b0 = '0;
		b1 = '0;
		b2 = '0;
		b3 = '0;
		if (!dec) begin
			for (int i = 0; i < 16; i++) a[8*i +: 8] = sk_pkg::fwd_box(s_in[8*i +: 8]);
			a = a ^ ark;
			for (int i = 0; i < 16; i++) t[8*i +: 8] = a[8*RS[i] +: 8];
			for (int c = 0; c < 4; c++) begin
				a0 = t[8*c +: 8];
				a1 = t[8*(4+c) +: 8];
				a2 = t[8*(8+c) +: 8];
				a3 = t[8*(12+c) +: 8];
				a1 = a1 ^ a2;
				a2 = a2 ^ a0;
				a3 = a3 ^ a2;
				s_out[8*c +: 8]      = a3;
				s_out[8*(4+c) +: 8]  = a0;
				s_out[8*(8+c) +: 8]  = a1;
				s_out[8*(12+c) +: 8] = a2;
			end
		end else begin
			for (int c = 0; c < 4; c++) begin
				b0 = s_in[8*c +: 8];
				b1 = s_in[8*(4+c) +: 8];
				b2 = s_in[8*(8+c) +: 8];
				b3 = s_in[8*(12+c) +: 8];
				a2 = b3 ^ b1;
				t[8*c +: 8]      = b1;
				t[8*(4+c) +: 8]  = b2 ^ a2;
				t[8*(8+c) +: 8]  = a2;
				t[8*(12+c) +: 8] = b0 ^ b3;
			end
			for (int i = 0; i < 16; i++) b[8*RS[i] +: 8] = t[8*i +: 8];
			b = b ^ ark;
			for (int i = 0; i < 16; i++) s_out[8*i +: 8] = sk_pkg::inv_box(b[8*i +: 8]);
		end
	end

endmodule

### sv/skinny128_384_tweakable_cipher.sv
// Channel   Dir  tdata fields (low bit up)                          tuser
// s_axis    in   block_low, block_high, tweak_low, tweak_high       req_type
// m_axis    out  result_low, result_high                            -
// cfg       in   wr_en, wr_idx (tk2_low, tk2_high, tk3_low, tk3_high), wr_data
//
// A beat is loaded, then runs every round through the single round unit
// with one round-key memory read per round, then its result is registered.
// Decrypt first advances TK1 to its last-round value.
// A key write while idle re-expands the key into the memory, one entry per
// cycle; a write during expansion restarts it; no beat is taken.
// Reset (arst_n, async low) clears control and key registers.
// The result waits in its register while m_axis_tready is low; no new beat
// is taken until it has left.
`include "assert_macros.svh"
module skinny128_384_tweakable_cipher #(
	parameter int NUM_ROUNDS = sk_pkg::NumRounds
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [255:0] s_axis_tdata,  // block_low, block_high, tweak_low, tweak_high
	input  logic         s_axis_tuser,  // req_type
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [127:0] m_axis_tdata,  // result_low, result_high
	input  logic         wr_en,
	input  logic [sk_pkg::CfgIdxW-1:0] wr_idx,
	input  logic [sk_pkg::RegW-1:0]    wr_data
);

	localparam int RW = $clog2(NUM_ROUNDS);

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_EXP  = 5'b00010,
		ST_FF   = 5'b00100,
		ST_RUN  = 5'b01000,
		ST_DONE = 5'b10000
	} st_t;

	st_t st_q;
	logic [RW-1:0] cnt_q;
	logic [127:0] tk2_q, tk3_q;   // key registers
	logic [127:0] tk2_d, tk3_d;   // key registers with this cycle's write merged
	logic [127:0] e2_q, e3_q;     // expansion working copies
	logic [5:0]   rc_q;
	logic [127:0] s_q, tk1_q;
	logic dec_q;
	logic pend_q;                 // result waiting to be delivered
	logic [127:0] res_q;

	logic [63:0] rk_mem [NUM_ROUNDS];
	logic [63:0] rk_rd;
	logic [RW-1:0] rd_addr;

	// key regs
	always_comb begin
		tk2_d = tk2_q;
		tk3_d = tk3_q;
		if (wr_en) begin
			case (sk_pkg::reg_idx_t'(wr_idx))
				sk_pkg::REG_TK2_LOW:  tk2_d[63:0]   = wr_data;
				sk_pkg::REG_TK2_HIGH: tk2_d[127:64] = wr_data;
				sk_pkg::REG_TK3_LOW:  tk3_d[63:0]   = wr_data;
				sk_pkg::REG_TK3_HIGH: tk3_d[127:64] = wr_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tk2_q <= '0;
			tk3_q <= '0;
		end else begin
			tk2_q <= tk2_d;
			tk3_q <= tk3_d;
		end
	end

	// expansion row: TK2^TK3 low half with round constant folded in
	logic [5:0] rc_n;
	logic [63:0] row;
	logic [127:0] p2, p3, e2_n, e3_n;
	always_comb begin
		rc_n = sk_pkg::rc_next(rc_q);
		row = e2_q[63:0] ^ e3_q[63:0];
		row[3:0]   = row[3:0] ^ rc_n[3:0];
		row[33:32] = row[33:32] ^ rc_n[5:4];
		p2 = sk_pkg::perm_tk(e2_q);
		p3 = sk_pkg::perm_tk(e3_q);
		e2_n = p2;
		e3_n = p3;
		for (int k = 0; k < 8; k++) begin
			e2_n[8*k +: 8] = {p2[8*k +: 7], p2[8*k+7] ^ p2[8*k+5]};
			e3_n[8*k +: 8] = {p3[8*k] ^ p3[8*k+6], p3[8*k+1 +: 7]};
		end
	end

	// round-key memory
	always_ff @(posedge clk) begin
		if (st_q == ST_EXP) rk_mem[cnt_q] <= row;
		rk_rd <= rk_mem[rd_addr];
	end

	// address for the next cycle's round
	logic [RW-1:0] next_r;
	logic start;
	assign start = s_axis_tvalid && s_axis_tready;
	always_comb begin
		next_r = '0;
		if (start) begin
			next_r = s_axis_tuser ? RW'(NUM_ROUNDS - 1) : '0;
		end else if (st_q == ST_FF && cnt_q == RW'(NUM_ROUNDS - 1)) begin
			next_r = RW'(NUM_ROUNDS - 1);
		end else if (st_q == ST_RUN) begin
			next_r = dec_q ? cnt_q - RW'(1) : cnt_q + RW'(1);
		end
	end
	assign rd_addr = (st_q == ST_RUN || start || st_q == ST_FF) ? next_r : cnt_q;

	logic [127:0] s_nx;
	logic [127:0] tk1_inv;
	sk_round u_round (
		.dec   (dec_q),
		.s_in  (s_q),
		.rk    (rk_rd),
		.tk1   (tk1_q[63:0]),
		.s_out (s_nx)
	);

	// inverse of the TK1 permutation: perm applied 15 more times, as its orbit has length 16
	always_comb begin
		tk1_inv = tk1_q;
		for (int i = 0; i < 15; i++) tk1_inv = sk_pkg::perm_tk(tk1_inv);
	end

	assign s_axis_tready = (st_q == ST_IDLE) && !wr_en && !pend_q;
	assign m_axis_tvalid = pend_q;
	assign m_axis_tdata  = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= ST_IDLE;
			cnt_q  <= '0;
			pend_q <= 1'b0;
			dec_q  <= 1'b0;
		end else begin
			if (pend_q && m_axis_tready) pend_q <= 1'b0;
			case (st_q)
				ST_IDLE: begin
					if (wr_en && wr_idx <= sk_pkg::CfgIdxW'(sk_pkg::REG_TK3_HIGH)) begin
						st_q  <= ST_EXP;
						cnt_q <= '0;
					end else if (start) begin
						dec_q <= s_axis_tuser;
						cnt_q <= s_axis_tuser ? '0 : '0;
						st_q  <= s_axis_tuser ? ST_FF : ST_RUN;
					end
				end
				ST_EXP: begin
					if (wr_en) begin
						cnt_q <= '0;
					end else begin
						if (cnt_q == RW'(NUM_ROUNDS - 1)) st_q <= ST_IDLE;
						cnt_q <= cnt_q + RW'(1);
					end
				end
				ST_FF: begin
					if (cnt_q == RW'(NUM_ROUNDS - 1)) begin
						st_q  <= ST_RUN;
						cnt_q <= RW'(NUM_ROUNDS - 1);
					end else begin
						cnt_q <= cnt_q + RW'(1);
					end
				end
				ST_RUN: begin
					if ((!dec_q && cnt_q == RW'(NUM_ROUNDS - 1)) || (dec_q && cnt_q == '0)) begin
						st_q <= ST_DONE;
					end
					cnt_q <= next_r;
				end
				ST_DONE: begin
					pend_q <= 1'b1;
					st_q   <= ST_IDLE;
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (st_q == ST_IDLE || (st_q == ST_EXP && wr_en)) begin
			// start (or restart) from the key as it stands after this edge
			e2_q <= tk2_d;
			e3_q <= tk3_d;
			rc_q <= '0;
		end else if (st_q == ST_EXP) begin
			e2_q <= e2_n;
			e3_q <= e3_n;
			rc_q <= rc_n;
		end
		if (start) begin
			s_q   <= s_axis_tdata[127:0];
			tk1_q <= s_axis_tdata[255:128];
		end else if (st_q == ST_FF) begin
			// advance TK1 to the value of the last round
			if (cnt_q != RW'(NUM_ROUNDS - 1)) tk1_q <= sk_pkg::perm_tk(tk1_q);
		end else if (st_q == ST_RUN) begin
			s_q   <= s_nx;
			tk1_q <= dec_q ? tk1_inv : sk_pkg::perm_tk(tk1_q);
		end
		if (st_q == ST_DONE) res_q <= s_q;
	end

	// key writes are to land between beats, which the block does not enforce; expansion must run uninterrupted
	`ASSERT_IMPL(a_exp_no_start, clk, arst_n, st_q == ST_EXP, !s_axis_tready, "beat taken during expansion")
	`ASSERT_NEXT(a_done_pend, clk, arst_n, st_q == ST_DONE, pend_q, "result not posted")
	`ASSERT_IMPL(a_pend_hold, clk, arst_n, pend_q && !m_axis_tready, !s_axis_tready, "beat taken over pending result")

endmodule
